/* hdl/smt_pkg.sv */
// sorted mark table package: payload structs, opcodes, controller/datapath interface
// no dependencies
package smt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam logic [7:0] ANY_TYPE = 8'hFF;
    localparam logic [7:0] CLASS_MASK = 8'hF0;
    localparam logic [7:0] EXCL_RESET = 8'd16;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_DEL_POS = 4'd1;
    localparam logic [3:0] OP_DEL_TYPE = 4'd2;
    localparam logic [3:0] OP_DEL_WEAK = 4'd3;
    localparam logic [3:0] OP_DEL_SIDE = 4'd4;
    localparam logic [3:0] OP_CLEAR = 4'd5;
    localparam logic [3:0] OP_GET = 4'd6;
    localparam logic [3:0] OP_PREV = 4'd7;
    localparam logic [3:0] OP_NEXT = 4'd8;
    localparam logic [3:0] OP_AROUND = 4'd9;
    localparam logic [3:0] OP_COUNT = 4'd10;
    localparam logic [3:0] OP_COUNT_EXCL = 4'd11;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [23:0] position;
        logic [23:0] range_end;
        logic [23:0] window;
        logic [7:0]  mark_type;
        logic [7:0]  type_mask;
        logic        from_start;
        logic        in_broadcast;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [23:0] found_position;
        logic [7:0]  found_type;
        logic        found_broadcast;
        logic [6:0]  count_value;
    } out_item_t;

    typedef struct packed {
        logic [23:0] pos;
        logic [7:0]  mtype;
        logic        bc;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item, clear scan state
        logic rd_en;    // issue read at scan index
        logic finish;   // form result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan index reached end of pass
        logic empty_pass; // no pass needed
    } dp_stat_t;

endpackage

/* hdl/smt_ram.sv */
// generic single-port-write, single-read RAM with registered read
// no dependencies
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/smt_ctrl.sv */
// sorted mark table controller: sequences one scan pass per item
// depends on smt_pkg
module smt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output smt_pkg::dp_cmd_t cmd,
    input  smt_pkg::dp_stat_t stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg;
        cmd = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.empty_pass) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                    if (stat.scan_last) begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                mvalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !mvalid_reg)
        else $error("result formed while previous still pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("accepting during scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_valid)
        else $error("finished item not presented");
endmodule

/* hdl/smt_dp.sv */
// sorted mark table datapath: scan pass with read/compact/insert over the store
// depends on smt_pkg, smt_ram
module smt_dp #(
    parameter int TABLE_DEPTH = smt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  smt_pkg::in_item_t  s_item,
    input  logic [7:0]         excluded_class,
    input  smt_pkg::dp_cmd_t   cmd,
    output smt_pkg::dp_stat_t  stat,
    output smt_pkg::out_item_t m_item
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    smt_pkg::in_item_t item_reg;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] ridx_reg;      // read index
    logic [CW-1:0] widx_reg;      // compaction write index
    logic          rvalid_reg;    // read data valid this cycle
    logic [CW-1:0] rpos_reg;      // index of data in rdata
    logic [CW-1:0] cnt_reg;
    logic          first_done_reg;
    // add: pending entry to shift forward
    smt_pkg::entry_t carry_reg;
    logic          carry_v_reg;
    // hits
    logic          ex_v_reg, pv_v_reg, nx_v_reg;
    smt_pkg::entry_t ex_reg, pv_reg, nx_reg;
    smt_pkg::out_item_t out_reg;

    logic          we;
    logic [AW-1:0] waddr;
    smt_pkg::entry_t wdata, rdata;

    smt_ram #(.WIDTH($bits(smt_pkg::entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(ridx_reg[AW-1:0]), .rdata(rdata));

    logic [3:0] op;
    logic [7:0] ty, mask;
    logic [23:0] p;
    assign op = item_reg.opcode;
    assign ty = item_reg.mark_type;
    assign mask = item_reg.type_mask;
    assign p = item_reg.position;

    logic is_del;
    assign is_del = (op == smt_pkg::OP_DEL_POS) || (op == smt_pkg::OP_DEL_TYPE) ||
                    (op == smt_pkg::OP_DEL_WEAK) || (op == smt_pkg::OP_DEL_SIDE) ||
                    (op == smt_pkg::OP_CLEAR);
    logic full;
    assign full = (occ_reg == CW'(TABLE_DEPTH));

    assign stat.scan_last = (ridx_reg + CW'(1) >= occ_reg);
    assign stat.empty_pass = (occ_reg == '0);

    logic tmatch;
    assign tmatch = (ty == smt_pkg::ANY_TYPE) || ((rdata.mtype & mask) == ty);

    logic removes;
    always_comb begin
        case (op)
            smt_pkg::OP_DEL_POS:  removes = !first_done_reg && rdata.pos == p;
            smt_pkg::OP_DEL_TYPE: removes = rdata.mtype == ty;
            smt_pkg::OP_DEL_WEAK: removes = rdata.pos > p && rdata.pos < item_reg.range_end &&
                                            rdata.mtype < (ty & smt_pkg::CLASS_MASK);
            smt_pkg::OP_DEL_SIDE: removes = item_reg.from_start ? rdata.pos < p : rdata.pos > p;
            default:              removes = 1'b1;
        endcase
    end

    // final write of carried entry at end of add pass
    logic add_tail;
    assign add_tail = cmd.finish && op == smt_pkg::OP_ADD && carry_v_reg && !full;

    always_comb begin
        we = 1'b0;
        waddr = rpos_reg[AW-1:0];
        wdata = rdata;
        if (rvalid_reg) begin
            if (op == smt_pkg::OP_ADD) begin
                if (rdata.pos == p) begin
                    we = ty > rdata.mtype;
                    wdata = '{pos: p, mtype: ty, bc: item_reg.in_broadcast};
                end else if (carry_v_reg && rdata.pos > p && !full) begin
                    we = 1'b1;
                    wdata = carry_reg;
                end
            end else if (is_del && !removes) begin
                we = 1'b1;
                waddr = widx_reg[AW-1:0];
            end
        end else if (add_tail) begin
            we = 1'b1;
            waddr = occ_reg[AW-1:0];
            wdata = carry_reg;
        end
    end

    // nearest selection for around
    logic [23:0] dprev, dnext;
    smt_pkg::entry_t near;
    logic near_v;
    always_comb begin
        dprev = p - pv_reg.pos;
        dnext = nx_reg.pos - p;
        near_v = pv_v_reg || nx_v_reg;
        if (pv_v_reg && nx_v_reg) begin
            near = (dprev > dnext) ? nx_reg : pv_reg;
        end else begin
            near = pv_v_reg ? pv_reg : nx_reg;
        end
        if (near_v && ((near.pos > p ? near.pos - p : p - near.pos) > item_reg.window)) begin
            near_v = 1'b0;
        end
    end

    function automatic void hit_v_reg_sel(input logic is_prev, inout smt_pkg::out_item_t r);
        logic v;
        smt_pkg::entry_t e;
        v = is_prev ? pv_v_reg : nx_v_reg;
        e = is_prev ? pv_reg : nx_reg;
        r.found = v;
        r.status = v ? smt_pkg::ST_OK : smt_pkg::ST_NOT_FOUND;
        if (v) begin
            {r.found_position, r.found_type, r.found_broadcast} = e;
        end
    endfunction

    smt_pkg::out_item_t res;
    always_comb begin
        res = '0;
        occ_next = occ_reg;
        case (op)
            smt_pkg::OP_ADD: begin
                if (ex_v_reg) begin
                    res.found = 1'b1;
                    res.found_position = ex_reg.pos;
                    res.found_type = (ty > ex_reg.mtype) ? ty : ex_reg.mtype;
                    res.found_broadcast = (ty > ex_reg.mtype) ? item_reg.in_broadcast
                                                              : ex_reg.bc;
                end else if (full) begin
                    res.status = smt_pkg::ST_FULL;
                end else begin
                    occ_next = occ_reg + CW'(1);
                    res.found = 1'b1;
                    res.found_position = p;
                    res.found_type = ty;
                    res.found_broadcast = item_reg.in_broadcast;
                end
            end
            smt_pkg::OP_DEL_POS, smt_pkg::OP_DEL_TYPE,
            smt_pkg::OP_DEL_WEAK, smt_pkg::OP_DEL_SIDE, smt_pkg::OP_CLEAR: begin
                occ_next = widx_reg;
                if ((op == smt_pkg::OP_DEL_POS || op == smt_pkg::OP_DEL_TYPE) &&
                    widx_reg == occ_reg) begin
                    res.status = smt_pkg::ST_NOT_FOUND;
                end
            end
            smt_pkg::OP_GET: begin
                res.found = ex_v_reg;
                res.status = ex_v_reg ? smt_pkg::ST_OK : smt_pkg::ST_NOT_FOUND;
                if (ex_v_reg) begin
                    {res.found_position, res.found_type, res.found_broadcast} = ex_reg;
                end
            end
            smt_pkg::OP_PREV, smt_pkg::OP_NEXT: begin
                hit_v_reg_sel(op == smt_pkg::OP_PREV, res);
            end
            smt_pkg::OP_AROUND: begin
                if (ex_v_reg && ((ex_reg.mtype & mask) == (ty & mask))) begin
                    res.found = 1'b1;
                    {res.found_position, res.found_type, res.found_broadcast} = ex_reg;
                end else if (near_v) begin
                    res.found = 1'b1;
                    {res.found_position, res.found_type, res.found_broadcast} = near;
                end else begin
                    res.status = smt_pkg::ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        if (op == smt_pkg::OP_COUNT || op == smt_pkg::OP_COUNT_EXCL) begin
            res.count_value = (op == smt_pkg::OP_COUNT && ty == smt_pkg::ANY_TYPE)
                              ? 7'(occ_reg) : 7'(cnt_reg);
        end else begin
            res.count_value = 7'(occ_next);
        end
    end

    logic cnt_hit;
    assign cnt_hit = (op == smt_pkg::OP_COUNT) ? ((rdata.mtype & mask) == ty)
                   : ((rdata.mtype & smt_pkg::CLASS_MASK) != excluded_class);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= cmd.rd_en;
            if (cmd.finish) begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
            ridx_reg <= '0;
            widx_reg <= '0;
            cnt_reg <= '0;
            first_done_reg <= 1'b0;
            carry_reg <= '{pos: s_item.position, mtype: s_item.mark_type,
                           bc: s_item.in_broadcast};
            carry_v_reg <= 1'b1;
            ex_v_reg <= 1'b0;
            pv_v_reg <= 1'b0;
            nx_v_reg <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                ridx_reg <= ridx_reg + CW'(1);
                rpos_reg <= ridx_reg;
            end
            if (rvalid_reg) begin
                if (is_del) begin
                    if (!removes) begin
                        widx_reg <= widx_reg + CW'(1);
                    end else if (op == smt_pkg::OP_DEL_POS) begin
                        first_done_reg <= 1'b1;
                    end
                end
                if (rdata.pos == p) begin
                    ex_v_reg <= !ex_v_reg || ex_v_reg;
                    if (!ex_v_reg) begin
                        ex_reg <= rdata;
                        carry_v_reg <= 1'b0;
                    end
                end
                if (rdata.pos < p && tmatch) begin
                    pv_v_reg <= 1'b1;
                    pv_reg <= rdata;
                end
                if (rdata.pos > p && tmatch && !nx_v_reg) begin
                    nx_v_reg <= 1'b1;
                    nx_reg <= rdata;
                end
                if (cnt_hit) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (op == smt_pkg::OP_ADD && carry_v_reg && rdata.pos > p && !full) begin
                    carry_reg <= rdata;
                end
            end
        end
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    assign m_item = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(TABLE_DEPTH))
        else $error("occupancy beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rvalid_reg && is_del) |-> widx_reg <= rpos_reg)
        else $error("compaction write ahead of read");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !rvalid_reg)
        else $error("finish with read in flight");
endmodule

/* hdl/sorted_mark_table.sv */
// sorted mark table top level: handshakes, config register, controller and datapath
// depends on smt_pkg, smt_ctrl, smt_dp, smt_ram
// Keeps up to TABLE_DEPTH marks sorted by position in one RAM. Every item makes one
// pass over the stored entries at one RAM read per cycle; m_valid rises once the pass
// ends and the result is formed, without a pass when the table is empty. The input waits
// until the result has transferred, so a new item is not accepted before the previous
// result is out. Adds shift the tail up in the same pass, deletes compact in place.
// One result per item.
module sorted_mark_table #(
    parameter int TABLE_DEPTH = smt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  smt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output smt_pkg::out_item_t m_item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);
    // excluded class register for count without class
    logic [7:0] excl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            excl_reg <= smt_pkg::EXCL_RESET;
        end else if (cfg_we) begin
            excl_reg <= cfg_wdata;
        end
    end

    smt_pkg::dp_cmd_t  cmd;
    smt_pkg::dp_stat_t stat;

    // controller: scan sequencing and handshakes
    smt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat));

    // datapath: table store and per-entry evaluation
    smt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .excluded_class(excl_reg),
        .cmd(cmd), .stat(stat), .m_item(m_item));
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for sorted_mark_table: bursty driver, stalling receiver
// depends on smt_pkg and the sorted_mark_table rtl
module tb;
    localparam int DEPTH = smt_pkg::TABLE_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid = 1'b0;
    logic               s_ready;
    smt_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    smt_pkg::out_item_t m_item;
    logic               cfg_we;
    logic [7:0]         cfg_wdata;

    sorted_mark_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    // shadow copy of the mark table
    smt_pkg::entry_t    marks[DEPTH];
    int                 mark_cnt;
    logic [7:0]         excl_class;

    smt_pkg::in_item_t  pending_ops[$];
    smt_pkg::out_item_t expected_results[$];
    int                 fail_count;
    int                 cycle_count = 0;

    function automatic bit type_hit(int i, logic [7:0] ty, logic [7:0] mask);
        return ty == smt_pkg::ANY_TYPE || (marks[i].mtype & mask) == ty;
    endfunction

    function automatic int prev_mark(logic [23:0] p, logic [7:0] ty, logic [7:0] mask);
        for (int i = mark_cnt - 1; i >= 0; i--)
            if (marks[i].pos < p && type_hit(i, ty, mask)) return i;
        return -1;
    endfunction

    function automatic int next_mark(logic [23:0] p, logic [7:0] ty, logic [7:0] mask);
        for (int i = 0; i < mark_cnt; i++)
            if (marks[i].pos > p && type_hit(i, ty, mask)) return i;
        return -1;
    endfunction

    function automatic int exact_mark(logic [23:0] p);
        for (int i = 0; i < mark_cnt; i++)
            if (marks[i].pos == p) return i;
        return -1;
    endfunction

    // compacting delete, returns how many marks went away
    function automatic int drop_marks(smt_pkg::in_item_t it);
        int  w;
        bit  gone;
        bit  first_done;
        int  removed;
        w = 0;
        first_done = 0;
        for (int r = 0; r < mark_cnt; r++) begin
            case (it.opcode)
                smt_pkg::OP_DEL_POS: begin
                    gone = !first_done && marks[r].pos == it.position;
                    if (gone) first_done = 1;
                end
                smt_pkg::OP_DEL_TYPE: gone = marks[r].mtype == it.mark_type;
                smt_pkg::OP_DEL_WEAK: gone = marks[r].pos > it.position
                                             && marks[r].pos < it.range_end
                                             && marks[r].mtype
                                                < (it.mark_type & smt_pkg::CLASS_MASK);
                smt_pkg::OP_DEL_SIDE: gone = it.from_start ? marks[r].pos < it.position
                                                           : marks[r].pos > it.position;
                default:              gone = 1;
            endcase
            if (!gone) begin
                marks[w] = marks[r];
                w++;
            end
        end
        removed = mark_cnt - w;
        mark_cnt = w;
        return removed;
    endfunction

    function automatic smt_pkg::out_item_t apply_mark_op(smt_pkg::in_item_t it);
        smt_pkg::out_item_t res;
        int                 hit;
        int                 a;
        int                 b;
        int                 k;
        int                 cnt;
        bit                 counted;
        logic [23:0]        span;
        res = '0;
        hit = -1;
        cnt = 0;
        counted = 0;
        case (it.opcode)
            smt_pkg::OP_ADD: begin
                hit = exact_mark(it.position);
                if (hit >= 0) begin
                    if (it.mark_type > marks[hit].mtype) begin
                        marks[hit].mtype = it.mark_type;
                        marks[hit].bc = it.in_broadcast;
                    end
                end else if (mark_cnt >= DEPTH) begin
                    res.status = smt_pkg::ST_FULL;
                end else begin
                    k = mark_cnt;
                    while (k > 0 && marks[k-1].pos > it.position) begin
                        marks[k] = marks[k-1];
                        k--;
                    end
                    marks[k] = '{it.position, it.mark_type, it.in_broadcast};
                    mark_cnt++;
                    hit = k;
                end
            end
            smt_pkg::OP_DEL_POS, smt_pkg::OP_DEL_TYPE:
                if (drop_marks(it) == 0) res.status = smt_pkg::ST_NOT_FOUND;
            smt_pkg::OP_DEL_WEAK, smt_pkg::OP_DEL_SIDE, smt_pkg::OP_CLEAR:
                void'(drop_marks(it));
            smt_pkg::OP_GET:  hit = exact_mark(it.position);
            smt_pkg::OP_PREV: hit = prev_mark(it.position, it.mark_type, it.type_mask);
            smt_pkg::OP_NEXT: hit = next_mark(it.position, it.mark_type, it.type_mask);
            smt_pkg::OP_AROUND: begin
                hit = exact_mark(it.position);
                if (!(hit >= 0 && (marks[hit].mtype & it.type_mask)
                                  == (it.mark_type & it.type_mask))) begin
                    a = prev_mark(it.position, it.mark_type, it.type_mask);
                    b = next_mark(it.position, it.mark_type, it.type_mask);
                    hit = -1;
                    // tie goes to the earlier mark
                    if (a >= 0 && b >= 0)
                        hit = (it.position - marks[a].pos > marks[b].pos - it.position) ? b : a;
                    else if (a >= 0) hit = a;
                    else if (b >= 0) hit = b;
                    if (hit >= 0) begin
                        span = marks[hit].pos > it.position ? marks[hit].pos - it.position
                                                            : it.position - marks[hit].pos;
                        if (span > it.window) hit = -1;
                    end
                end
            end
            smt_pkg::OP_COUNT: begin
                counted = 1;
                if (it.mark_type == smt_pkg::ANY_TYPE) cnt = mark_cnt;
                else
                    for (int i = 0; i < mark_cnt; i++)
                        if ((marks[i].mtype & it.type_mask) == it.mark_type) cnt++;
            end
            smt_pkg::OP_COUNT_EXCL: begin
                counted = 1;
                for (int i = 0; i < mark_cnt; i++)
                    if ((marks[i].mtype & smt_pkg::CLASS_MASK) != excl_class) cnt++;
            end
            default: ;
        endcase
        if (hit < 0 && (it.opcode == smt_pkg::OP_GET || it.opcode == smt_pkg::OP_PREV
                        || it.opcode == smt_pkg::OP_NEXT || it.opcode == smt_pkg::OP_AROUND))
            res.status = smt_pkg::ST_NOT_FOUND;
        if (hit >= 0) begin
            res.found = 1'b1;
            res.found_position = marks[hit].pos;
            res.found_type = marks[hit].mtype;
            res.found_broadcast = marks[hit].bc;
        end
        res.count_value = 7'(counted ? cnt : mark_cnt);
        return res;
    endfunction

    // accept seen at the last rising edge; prediction is done there too
    logic s_ready_seen;
    always @(posedge aclk) begin
        s_ready_seen <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            s_ready_seen <= 1'b1;
            expected_results.push_back(apply_mark_op(s_item));
        end
    end

    // driver: bursts of transfers separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_valid || s_ready_seen) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                s_item <= pending_ops.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: alternates long ready stretches with choppy ones
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[7]) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(3, 0) != 0);
    end

    // monitor
    always @(posedge aclk) begin
        smt_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_item.status != want.status) begin
                    $error("status exp %0d got %0d", want.status, m_item.status);
                    fail_count++;
                end
                if (m_item.found != want.found) begin
                    $error("found exp %0d got %0d", want.found, m_item.found);
                    fail_count++;
                end
                if (m_item.found_position != want.found_position) begin
                    $error("found_position exp %0h got %0h",
                           want.found_position, m_item.found_position);
                    fail_count++;
                end
                if (m_item.found_type != want.found_type) begin
                    $error("found_type exp %0h got %0h", want.found_type, m_item.found_type);
                    fail_count++;
                end
                if (m_item.found_broadcast != want.found_broadcast) begin
                    $error("found_broadcast exp %0d got %0d",
                           want.found_broadcast, m_item.found_broadcast);
                    fail_count++;
                end
                if (m_item.count_value != want.count_value) begin
                    $error("count_value exp %0d got %0d", want.count_value, m_item.count_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_mark_table verification failed");
            $finish;
        end
    end

    // position near a small cluster so lookups, ties and duplicates happen
    function automatic logic [23:0] near_pos();
        if ($urandom_range(9, 0) == 0) return 24'($urandom);
        return 24'($urandom_range(200, 0));
    endfunction

    function automatic smt_pkg::in_item_t rand_op();
        smt_pkg::in_item_t it;
        int                pick;
        it = '0;
        it.window = 24'($urandom);
        it.mark_type = 8'($urandom);
        it.type_mask = 8'($urandom);
        it.from_start = 1'($urandom);
        it.in_broadcast = 1'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 40)      it.opcode = smt_pkg::OP_ADD;
        else if (pick < 97) it.opcode = 4'($urandom_range(11, 1));
        else                it.opcode = 4'($urandom_range(15, 12));
        // clears are kept rare so the table fills
        if (it.opcode == smt_pkg::OP_CLEAR && $urandom_range(3, 0) != 0)
            it.opcode = smt_pkg::OP_ADD;
        it.position = near_pos();
        it.range_end = near_pos();
        if ($urandom_range(1, 0)) it.window = 24'($urandom_range(40, 0));
        if ($urandom_range(2, 0) == 0) it.mark_type = smt_pkg::ANY_TYPE;
        if ($urandom_range(1, 0)) it.type_mask = 8'hFF;
        return it;
    endfunction

    // wait until every queued item has gone through and its result has transferred
    task automatic drain();
        wait (pending_ops.size() == 0);
        @(posedge aclk);
        while (expected_results.size() > 0 || s_valid) @(posedge aclk);
    endtask

    // run ops to completion; they drain through the driver
    task automatic run_ops(int n);
        for (int i = 0; i < n; i++) pending_ops.push_back(rand_op());
        drain();
    endtask

    task automatic set_excl(logic [7:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        excl_class = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic smt_pkg::in_item_t mk(logic [3:0] op, logic [23:0] p, logic [7:0] ty);
        smt_pkg::in_item_t it;
        it = '0;
        it.opcode = op;
        it.position = p;
        it.mark_type = ty;
        it.type_mask = 8'hFF;
        it.window = 24'hFFFFFF;
        return it;
    endfunction

    initial begin
        smt_pkg::in_item_t it;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        mark_cnt = 0;
        excl_class = smt_pkg::EXCL_RESET;
        for (int i = 0; i < DEPTH; i++) marks[i] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, each op, and the documented corner cases
        pending_ops.push_back(mk(smt_pkg::OP_GET, 24'd5, 8'd0));      // empty table lookup
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'hFFFFFF, 8'hFF));
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'd0, 8'h00));
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'd100, 8'h20));
        it = mk(smt_pkg::OP_ADD, 24'd100, 8'h30); it.in_broadcast = 1; // stronger type replaces
        pending_ops.push_back(it);
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'd100, 8'h10));   // weaker type kept
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'd90, 8'h12));
        pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'd110, 8'h12));
        pending_ops.push_back(mk(smt_pkg::OP_AROUND, 24'd100, 8'h12)); // exact miss by type, tie
        pending_ops.push_back(mk(smt_pkg::OP_AROUND, 24'd100, 8'h30)); // exact match wins
        it = mk(smt_pkg::OP_AROUND, 24'd50, 8'h12); it.window = 24'd10; // out of window
        pending_ops.push_back(it);
        pending_ops.push_back(mk(smt_pkg::OP_PREV, 24'd100, smt_pkg::ANY_TYPE));
        pending_ops.push_back(mk(smt_pkg::OP_NEXT, 24'd100, 8'h12));
        it = mk(smt_pkg::OP_COUNT, 24'd0, 8'h10); it.type_mask = 8'hF0;
        pending_ops.push_back(it);
        pending_ops.push_back(mk(smt_pkg::OP_COUNT, 24'd0, smt_pkg::ANY_TYPE));
        pending_ops.push_back(mk(smt_pkg::OP_COUNT_EXCL, 24'd0, 8'd0));
        it = mk(smt_pkg::OP_DEL_WEAK, 24'd0, 8'hFF); it.range_end = 24'd200;
        pending_ops.push_back(it);
        pending_ops.push_back(mk(smt_pkg::OP_DEL_POS, 24'd7, 8'd0));  // nothing removed
        pending_ops.push_back(mk(smt_pkg::OP_DEL_TYPE, 24'd0, 8'hFF));
        it = mk(smt_pkg::OP_DEL_SIDE, 24'd95, 8'd0); it.from_start = 1;
        pending_ops.push_back(it);
        pending_ops.push_back(mk(smt_pkg::OP_DEL_SIDE, 24'd95, 8'd0));
        pending_ops.push_back(mk(4'd15, 24'd0, 8'd0));
        pending_ops.push_back(mk(smt_pkg::OP_CLEAR, 24'd0, 8'd0));
        // fill to full, then one more distinct position
        for (int i = 0; i <= DEPTH; i++)
            pending_ops.push_back(mk(smt_pkg::OP_ADD, 24'(i * 3), 8'(i)));
        drain();
        pending_ops.push_back(mk(smt_pkg::OP_COUNT_EXCL, 24'd0, 8'd0));
        pending_ops.push_back(mk(smt_pkg::OP_CLEAR, 24'd0, 8'd0));
        drain();

        // random phases over several class settings
        repeat (DEPTH + 8) @(posedge aclk);
        set_excl(8'h00);
        run_ops(90);
        repeat (DEPTH + 8) @(posedge aclk);
        set_excl(8'hFF);
        run_ops(90);
        repeat (DEPTH + 8) @(posedge aclk);
        set_excl(8'h30);
        run_ops(90);
        repeat (DEPTH + 8) @(posedge aclk);
        set_excl(8'($urandom_range(15, 0) << 4));
        run_ops(90);

        repeat (DEPTH * 2) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("sorted_mark_table verification clean");
        end else begin
            $display("sorted_mark_table verification failed");
        end
        $finish;
    end
endmodule

/* sorted_mark_table.f */
hdl/smt_pkg.sv
hdl/smt_ram.sv
hdl/smt_ctrl.sv
hdl/smt_dp.sv
hdl/sorted_mark_table.sv
dv/tb.sv
